// ----- rtl/parallel_port_registers_unit_assert.svh -----
// Assertion macros for the parallel port register block checker.
// Each macro checks one implication on the rising edge of i_clk and is disabled during reset.
`ifndef PARALLEL_PORT_REGISTERS_UNIT_ASSERT_SVH
`define PARALLEL_PORT_REGISTERS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ppr_pkg.sv -----
// Shared types and constants for the parallel port register block.
// It has no dependencies. Every other RTL module imports it.
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

    // One bus access, as it arrives on the input channel.
    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  value;
    } t_in_item;

    // One result beat, as it leaves on the output channel.
    typedef struct packed {
        logic [7:0] read_data;
        logic       printer_valid;
        logic [7:0] printer_byte;
        logic       irq_lowered;
        logic       irq_raised;
        logic [3:0] irq_line;
    } t_out_item;

    // The architectural state of one port.
    typedef struct packed {
        logic [7:0] data_latch;
        logic [4:0] status_bits;
        logic [5:0] control_bits;
        logic       init_pending;
    } t_port_state;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Register offsets within a port.
    localparam logic [2:0] OFF_DATA    = 3'd0;
    localparam logic [2:0] OFF_STATUS  = 3'd1;
    localparam logic [2:0] OFF_CONTROL = 3'd2;

    // Address bits 9..3 of the second port (base 0x278).
    localparam logic [6:0] PORT1_SEL = 7'h4F;

    // Status bit positions.
    localparam int ST_BUSY = 4;
    localparam int ST_ACK  = 3;
    localparam int ST_SLCT = 1;

    // Control bit positions.
    localparam int CT_STROBE = 0;
    localparam int CT_INIT   = 2;
    localparam int CT_SLCTIN = 3;
    localparam int CT_IRQ    = 4;
    localparam int CT_INPUT  = 5;

    // Data read value in input mode.
    localparam logic [7:0] DATA_INPUT_MODE = 8'hFF;

    // Reset values of the first port; every other port resets to zero.
    localparam logic [4:0] STATUS_RST_PORT0  = 5'h1B;
    localparam logic [5:0] CONTROL_RST_PORT0 = 6'h0C;

    // Configuration register indexes and reset values.
    localparam logic       REG_IRQ_PORT0     = 1'b0;
    localparam logic       REG_IRQ_PORT1     = 1'b1;
    localparam logic [3:0] IRQ_PORT0_RST     = 4'd7;
    localparam logic [3:0] IRQ_PORT1_RST     = 4'd0;

endpackage

`default_nettype wire

// ----- rtl/ppr_cfg_regs.sv -----
// APB-style configuration registers holding the interrupt line of each port.
// Depends on ppr_pkg for register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module ppr_cfg_regs
    import ppr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [3:0]  o_irq_line_port0,
    output logic      [3:0]  o_irq_line_port1
);

    logic [3:0] r_irq_line_port0;
    logic [3:0] r_irq_line_port1;
    logic       w_wr;
    logic       w_index;

    // Registers sit at byte addresses 0 and 4, so bit 2 picks the register.
    assign pready  = 1'b1;
    assign w_wr    = psel & penable & pwrite & pready;
    assign w_index = paddr[2];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_line_port0 <= IRQ_PORT0_RST;
            r_irq_line_port1 <= IRQ_PORT1_RST;
        end else if (w_wr) begin
            if (w_index == REG_IRQ_PORT0) begin
                r_irq_line_port0 <= pwdata[3:0];
            end else begin
                r_irq_line_port1 <= pwdata[3:0];
            end
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        if (w_index == REG_IRQ_PORT1) begin
            prdata[3:0] = r_irq_line_port1;
        end else begin
            prdata[3:0] = r_irq_line_port0;
        end
    end

    assign o_irq_line_port0 = r_irq_line_port0;
    assign o_irq_line_port1 = r_irq_line_port1;

endmodule

`default_nettype wire

// ----- rtl/ppr_access.sv -----
// Combinational update of one port for one bus access: next state and result beat.
// Depends on ppr_pkg for the item, result and state types and the bit positions.
`timescale 1ns / 1ps
`default_nettype none

module ppr_access
    import ppr_pkg::*;
(
    input  wire t_in_item    i_item,
    input  wire t_port_state i_cur,
    input  wire logic [3:0]  i_irq_line,
    output t_port_state      o_nxt,
    output t_out_item        o_result
);

    logic [2:0] w_offset;
    logic [4:0] w_st;
    logic [5:0] w_ct;
    logic [7:0] w_dl;
    logic       w_ip;

    assign w_offset = i_item.address[2:0];

    always_comb begin
        w_st     = i_cur.status_bits;
        w_ct     = i_cur.control_bits;
        w_dl     = i_cur.data_latch;
        w_ip     = i_cur.init_pending;
        o_result = '0;

        if (i_item.kind == KIND_READ) begin
            unique case (w_offset)
                OFF_DATA: begin
                    o_result.read_data = w_ct[CT_INPUT] ? DATA_INPUT_MODE : w_dl;
                end
                OFF_STATUS: begin
                    o_result.read_data = {w_st, 3'b000};
                    // Acknowledge a pending ack.
                    if (!w_st[ST_ACK]) begin
                        w_st[ST_ACK]         = 1'b1;
                        o_result.irq_lowered = w_ct[CT_IRQ];
                    end
                    // Finish a pending printer init.
                    if (w_ip) begin
                        w_st[ST_BUSY]       = 1'b1;
                        w_st[ST_SLCT]       = 1'b1;
                        w_st[ST_ACK]        = 1'b0;
                        o_result.irq_raised = w_ct[CT_IRQ];
                        w_ip                = 1'b0;
                    end
                end
                OFF_CONTROL: begin
                    o_result.read_data = {2'b00, w_ct};
                end
                default: begin
                end
            endcase
        end else begin
            unique case (w_offset)
                OFF_DATA: begin
                    w_dl = i_item.value;
                end
                OFF_CONTROL: begin
                    // A rising strobe hands the latch to an online printer,
                    // judged by the old select and interrupt enable.
                    if (i_item.value[CT_STROBE] && !i_cur.control_bits[CT_STROBE]
                            && w_st[ST_SLCT]) begin
                        o_result.printer_valid = 1'b1;
                        o_result.printer_byte  = w_dl;
                        o_result.irq_raised    = w_ct[CT_IRQ];
                        w_st[ST_ACK]           = 1'b0;
                        w_st[ST_BUSY]          = 1'b1;
                    end
                    // A rising init resets the printer until the next status read.
                    if (i_item.value[CT_INIT] && !i_cur.control_bits[CT_INIT]) begin
                        w_st[ST_BUSY] = 1'b0;
                        w_st[ST_SLCT] = 1'b0;
                        w_ip          = 1'b1;
                    end
                    w_ct          = i_item.value[5:0];
                    w_st[ST_SLCT] = w_ct[CT_SLCTIN];
                end
                default: begin
                end
            endcase
        end

        o_result.irq_line = i_irq_line;
        o_nxt.data_latch   = w_dl;
        o_nxt.status_bits  = w_st;
        o_nxt.control_bits = w_ct;
        o_nxt.init_pending = w_ip;
    end

endmodule

`default_nettype wire

// ----- rtl/parallel_port_registers_unit.sv -----
// Top level of the parallel port register block: channel registers and per-port state.
// Depends on ppr_pkg, ppr_cfg_regs and ppr_access.
`timescale 1ns / 1ps
`default_nettype none

// Register file of one or two PC standard parallel ports behind I/O bus accesses. Each input
// beat is one read or write and yields exactly one result beat. An access is held in the
// input register and then moves into the result register, and the block takes one access
// every cycle while the result channel does not stall; the port state is updated as the
// access moves into the result register, so the next access already sees it. While the result
// register is stalled and full, one further access waits in the input register and the input
// channel stalls. The interrupt line registers are written through the APB-style port and
// should only change while no access is in flight.
module parallel_port_registers_unit
    import ppr_pkg::*;
#(
    parameter int NUM_PORTS = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Access channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    t_in_item    r_in;
    logic        r_in_valid;
    logic        n_in_valid;
    t_out_item   r_out;
    logic        r_out_valid;
    logic        n_out_valid;
    t_port_state r_state [NUM_PORTS];

    logic        w_in_accept;
    logic        w_advance;
    logic [PW-1:0] w_port;
    logic [3:0]  w_irq_line_port0;
    logic [3:0]  w_irq_line_port1;
    logic [3:0]  w_irq_line;
    t_port_state w_nxt;
    t_out_item   w_result;

    // Configuration registers.
    ppr_cfg_regs u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_irq_line_port0 (w_irq_line_port0),
        .o_irq_line_port1 (w_irq_line_port1)
    );

    // Handshake: the held access moves on whenever the result register is free or draining.
    assign w_advance   = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall  = r_in_valid & ~w_advance;
    assign w_in_accept = i_in_valid & ~o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= i_in_item;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    // Port decode: the 0x278 window selects the second port when it exists.
    always_comb begin
        w_port = '0;
        if (NUM_PORTS > 1 && r_in.address[9:3] == PORT1_SEL) begin
            w_port = PW'(1);
        end
        w_irq_line = (w_port != '0) ? w_irq_line_port1 : w_irq_line_port0;
    end

    // Access logic for the addressed port.
    ppr_access u_access (
        .i_item     (r_in),
        .i_cur      (r_state[w_port]),
        .i_irq_line (w_irq_line),
        .o_nxt      (w_nxt),
        .o_result   (w_result)
    );

    // Per-port state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_state[i].data_latch   <= '0;
                r_state[i].status_bits  <= (i == 0) ? STATUS_RST_PORT0 : '0;
                r_state[i].control_bits <= (i == 0) ? CONTROL_RST_PORT0 : '0;
                r_state[i].init_pending <= 1'b0;
            end
        end else if (w_advance) begin
            r_state[w_port] <= w_nxt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ----- rtl/ppr_checker.sv -----
// Port-level checker for the parallel port register block, bound to the top level.
// Depends on ppr_pkg and the assertion macros in parallel_port_registers_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "parallel_port_registers_unit_assert.svh"

module ppr_checker
    import ppr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire t_out_item   o_out_item
);

    // A held result beat stays put until it is taken.
    `PPR_ASSERT_NXT(a_out_hold,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item),
        "result beat changed while stalled")

    // The input side only waits behind a full, stalled result register.
    `PPR_ASSERT_IMP(a_in_stall_cause,
        o_in_stall,
        o_out_valid && i_out_stall,
        "input stalled without a blocked result")

    // A printer hand-off comes from a write, so it reads zero and lowers nothing.
    `PPR_ASSERT_IMP(a_print_is_write,
        o_out_valid && o_out_item.printer_valid,
        o_out_item.read_data == 8'h00 && !o_out_item.irq_lowered,
        "printer beat with read data or lowering")

    // Lowering the interrupt only happens on a status read that saw ack clear.
    `PPR_ASSERT_IMP(a_lower_ack_clear,
        o_out_valid && o_out_item.irq_lowered,
        !o_out_item.read_data[6] && !o_out_item.printer_valid,
        "interrupt lowered while ack was set")

endmodule

bind parallel_port_registers_unit ppr_checker u_ppr_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for parallel_port_registers_unit: directed table plus random accesses.
// Depends on ppr_pkg and the RTL; a predictor gives each expected beat the table leaves untyped.
`timescale 1ns / 1ps

module tb_top;
    import ppr_pkg::*;

    localparam int NUM_DIR       = 26;
    localparam int ITEMS_PER_RUN = 376;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int NUM_PHASES    = 5;

    // One row of the directed table: the access and, where obvious, its result.
    typedef struct packed {
        t_in_item  acc;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_item = '0;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic [31:0] prdata;
    logic        pready;

    parallel_port_registers_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the port state and the interrupt line registers.
    logic [7:0] latch_m   [2];
    logic [4:0] status_m  [2];
    logic [5:0] control_m [2];
    logic       pending_m [2];
    logic [3:0] irq_cfg   [2];

    t_out_item due_results [$];
    t_dir_row  access_notes [$];

    int errors = 0;
    int accepted_n = 0;
    int printed_n = 0;
    int raised_n = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    // Directed table: reset values, every register and kind, both ports, the special cases.
    t_dir_row dir_rows [0:NUM_DIR-1] = '{
        // Reset state of port zero and an unused offset on port one.
        {KIND_READ,  16'h0379, 8'h00, 1'b1, 8'hD8, 1'b0, 8'h00, 1'b0, 1'b0, 4'd7},
        {KIND_READ,  16'h037A, 8'h00, 1'b1, 8'h0C, 1'b0, 8'h00, 1'b0, 1'b0, 4'd7},
        {KIND_READ,  16'h0378, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 4'd7},
        {KIND_READ,  16'h027F, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0},
        {KIND_READ,  16'h0279, 8'h00, 1'b0, 23'd0},
        // Data write, ignored status write, ignored unused write.
        {KIND_WRITE, 16'h0378, 8'hFF, 1'b0, 23'd0},
        {KIND_WRITE, 16'h0379, 8'h00, 1'b0, 23'd0},
        {KIND_WRITE, 16'h037F, 8'hAA, 1'b0, 23'd0},
        // Enable irq, strobe out a byte, acknowledge it, then an init edge.
        {KIND_WRITE, 16'h037A, 8'h18, 1'b0, 23'd0},
        {KIND_WRITE, 16'h037A, 8'h19, 1'b0, 23'd0},
        {KIND_READ,  16'h0379, 8'h00, 1'b0, 23'd0},
        {KIND_WRITE, 16'h037A, 8'h1C, 1'b0, 23'd0},
        {KIND_READ,  16'h0379, 8'h00, 1'b0, 23'd0},
        // Input mode makes data reads return all ones.
        {KIND_WRITE, 16'h037A, 8'h3C, 1'b0, 23'd0},
        {KIND_READ,  16'h0378, 8'h00, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 4'd7},
        {KIND_WRITE, 16'hFFFF, 8'hFF, 1'b0, 23'd0},
        {KIND_READ,  16'h0000, 8'h00, 1'b0, 23'd0},
        // Port one: strobe without irq, strobe while offline, high control bits.
        {KIND_WRITE, 16'h0278, 8'h5A, 1'b0, 23'd0},
        {KIND_WRITE, 16'h027A, 8'h08, 1'b0, 23'd0},
        {KIND_WRITE, 16'h027A, 8'h09, 1'b0, 23'd0},
        {KIND_READ,  16'h0279, 8'h00, 1'b0, 23'd0},
        {KIND_WRITE, 16'h027A, 8'h00, 1'b0, 23'd0},
        {KIND_WRITE, 16'h027A, 8'h01, 1'b0, 23'd0},
        {KIND_WRITE, 16'h027A, 8'hC0, 1'b0, 23'd0},
        {KIND_READ,  16'hFA79, 8'h00, 1'b0, 23'd0},
        {KIND_READ,  16'h027A, 8'h00, 1'b0, 23'd0}
    };

    // Interrupt line settings per phase; both extremes appear for both ports.
    logic [3:0] irq0_plan [NUM_PHASES] = '{4'd15, 4'd0, 4'd9, 4'd15, 4'd0};
    logic [3:0] irq1_plan [NUM_PHASES] = '{4'd0, 4'd15, 4'd3, 4'd15, 4'd11};
    int idle_plan  [NUM_PHASES] = '{0, 86, 0, 20, 0};
    int stall_plan [NUM_PHASES] = '{0, 0, 86, 20, 0};

    task automatic reset_model();
        latch_m[0] = '0;
        latch_m[1] = '0;
        status_m[0] = STATUS_RST_PORT0;
        status_m[1] = '0;
        control_m[0] = CONTROL_RST_PORT0;
        control_m[1] = '0;
        pending_m[0] = 1'b0;
        pending_m[1] = 1'b0;
        irq_cfg[0] = IRQ_PORT0_RST;
        irq_cfg[1] = IRQ_PORT1_RST;
    endtask

    // Apply one bus access to the port state and return the result beat it yields.
    function automatic t_out_item spp_access(t_in_item acc);
        t_out_item  res;
        logic       sel;
        logic [4:0] st;
        logic [5:0] ct;
        res = '0;
        sel = (acc.address[9:3] == PORT1_SEL);
        st = status_m[sel];
        ct = control_m[sel];
        if (acc.kind == KIND_READ) begin
            case (acc.address[2:0])
                OFF_DATA: begin
                    res.read_data = ct[CT_INPUT] ? DATA_INPUT_MODE : latch_m[sel];
                end
                OFF_STATUS: begin
                    res.read_data = {st, 3'b000};
                    // A status read acknowledges, then completes any init in progress.
                    if (!st[ST_ACK]) begin
                        st[ST_ACK] = 1'b1;
                        res.irq_lowered = ct[CT_IRQ];
                    end
                    if (pending_m[sel]) begin
                        st[ST_BUSY] = 1'b1;
                        st[ST_SLCT] = 1'b1;
                        st[ST_ACK] = 1'b0;
                        res.irq_raised = ct[CT_IRQ];
                        pending_m[sel] = 1'b0;
                    end
                end
                OFF_CONTROL: begin
                    res.read_data = {2'b00, ct};
                end
                default: ;
            endcase
        end else begin
            case (acc.address[2:0])
                OFF_DATA: begin
                    latch_m[sel] = acc.value;
                end
                OFF_CONTROL: begin
                    // The strobe edge sees the old irq enable and select.
                    if (acc.value[CT_STROBE] && !ct[CT_STROBE] && st[ST_SLCT]) begin
                        res.printer_valid = 1'b1;
                        res.printer_byte = latch_m[sel];
                        res.irq_raised = ct[CT_IRQ];
                        st[ST_ACK] = 1'b0;
                        st[ST_BUSY] = 1'b1;
                    end
                    if (acc.value[CT_INIT] && !ct[CT_INIT]) begin
                        st[ST_BUSY] = 1'b0;
                        st[ST_SLCT] = 1'b0;
                        pending_m[sel] = 1'b1;
                    end
                    ct = acc.value[5:0];
                    st[ST_SLCT] = ct[CT_SLCTIN];
                end
                default: ;
            endcase
        end
        status_m[sel] = st;
        control_m[sel] = ct;
        res.irq_line = irq_cfg[sel];
        return res;
    endfunction

    // Random access: mostly the two port windows and the three live offsets.
    function automatic t_in_item random_access();
        t_in_item a;
        int       pick;
        int       off_pick;
        logic [2:0] off;
        logic [5:0] upper;
        pick = $urandom_range(99);
        off_pick = $urandom_range(9);
        off = (off_pick < 9) ? 3'(off_pick % 3) : 3'($urandom_range(7));
        upper = ($urandom_range(3) == 0) ? 6'($urandom) : 6'd0;
        a.kind = 1'($urandom);
        a.value = 8'($urandom);
        if (pick < 45)
            a.address = {upper, PORT1_SEL, off};
        else if (pick < 90)
            a.address = {upper, 7'h6F, off};
        else
            a.address = 16'($urandom);
        // Keep the printer online most of the time so strobes go through.
        if ($urandom_range(3) != 0)
            a.value[CT_SLCTIN] = 1'b1;
        return a;
    endfunction

    // Offer one beat on the access channel and wait until it is taken.
    task automatic send_access(t_in_item acc, logic typed, t_out_item want);
        t_dir_row note;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        note.acc = acc;
        note.typed = typed;
        note.want = want;
        access_notes.push_back(note);
        i_in_valid <= 1'b1;
        i_in_item <= acc;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Wait until every expected beat has been received.
    task automatic drain_results();
        @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Write one interrupt line register, then read it back.
    task automatic write_irq_line(logic idx, logic [3:0] line);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {28'd0, line};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        irq_cfg[idx] = line;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {28'd0, line}) begin
            $error("irq line register %0d: expected %0h, actual %0h", idx, line, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Accept side: predict each taken access; result side: compare each taken beat.
    always @(posedge i_clk) begin
        t_dir_row  note;
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                note = access_notes.pop_front();
                want = spp_access(note.acc);
                if (note.typed)
                    want = note.want;
                due_results.push_back(want);
                accepted_n++;
                printed_n += want.printer_valid;
                raised_n += want.irq_raised;
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result beat with no access outstanding");
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    if (o_out_item.read_data !== want.read_data) begin
                        $error("read_data: expected %0h, actual %0h",
                               want.read_data, o_out_item.read_data);
                        errors++;
                    end
                    if (o_out_item.printer_valid !== want.printer_valid) begin
                        $error("printer_valid: expected %0b, actual %0b",
                               want.printer_valid, o_out_item.printer_valid);
                        errors++;
                    end
                    if (o_out_item.printer_byte !== want.printer_byte) begin
                        $error("printer_byte: expected %0h, actual %0h",
                               want.printer_byte, o_out_item.printer_byte);
                        errors++;
                    end
                    if (o_out_item.irq_lowered !== want.irq_lowered) begin
                        $error("irq_lowered: expected %0b, actual %0b",
                               want.irq_lowered, o_out_item.irq_lowered);
                        errors++;
                    end
                    if (o_out_item.irq_raised !== want.irq_raised) begin
                        $error("irq_raised: expected %0b, actual %0b",
                               want.irq_raised, o_out_item.irq_raised);
                        errors++;
                    end
                    if (o_out_item.irq_line !== want.irq_line) begin
                        $error("irq_line: expected %0d, actual %0d",
                               want.irq_line, o_out_item.irq_line);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when asked for.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then the random phases.
    initial begin
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIR; i++)
            send_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].want);
        i_in_valid <= 1'b0;
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_irq_line(REG_IRQ_PORT0, irq0_plan[ph]);
            write_irq_line(REG_IRQ_PORT1, irq1_plan[ph]);
            sender_idle_pct = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            // The last phase starts with a long receiver hold-off to fill the block.
            if (ph == NUM_PHASES - 1)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_RUN; n++)
                send_access(random_access(), 1'b0, '0);
            i_in_valid <= 1'b0;
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d accesses (%0d directed) over %0d traffic phases.",
                 accepted_n, NUM_DIR, NUM_PHASES);
        $display("Printer beats seen: %0d, interrupt raises seen: %0d.", printed_n, raised_n);
        if (errors == 0 && due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ppr_pkg.sv
rtl/ppr_cfg_regs.sv
rtl/ppr_access.sv
rtl/parallel_port_registers_unit.sv
rtl/ppr_checker.sv
test/tb_top.sv
